/* sv/ftmc_pkg.sv */
// Shared types and constants for the flow table message counter.
// Field widths, result status codes, table entry and result records.
// No dependencies.
package ftmc_pkg;

   localparam int ADDR_W     = 32;
   localparam int PORT_W     = 16;
   localparam int COUNT_W    = 32;
   localparam int SLOT_W     = 7;
   localparam int STATUS_W   = 2;
   localparam int LIMIT_W    = 8;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd100;

   localparam logic [STATUS_W-1:0] ST_COUNTED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_REMOVED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd2;

   typedef struct packed {
      logic [ADDR_W-1:0]  addr;
      logic [PORT_W-1:0]  port;
      logic [COUNT_W-1:0] count;
   } entry_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [COUNT_W-1:0]  count;
   } result_type;

endpackage

/* sv/flow_table_message_counter.sv */
// Top level of the flow table message counter: table memory, search, update
// and shift-down sequencer. Depends on ftmc_pkg and ftmc_rsp_reg.
//
//   channel   direction  payload
//   req_      in         tdata: source_address, source_port; tuser: is_close
//   rsp_      out        tdata: slot, message_count; tuser: status
//   csr_      in         wr_data: entry_limit, no read-back
//
// A new item is accepted only once the last one, shift-down included, is
// done. The search reads the live entries from slot zero up until one
// matches or none is left; an empty table skips it. A close on a stored
// entry then moves every live entry above its slot down one slot. The single
// read port of the table memory, one entry a cycle, sets the pace of both.
// Reset clears the live count and restores the limit to its default. Table
// entries at and above the live count are never searched.
// A stalled result holds in the output register while the next item is
// accepted and searched. That item then waits in its update state until the
// register frees.
module flow_table_message_counter
   import ftmc_pkg::*;
#(
   parameter int TABLE_DEPTH = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [31:0] source_address, [47:32] source_port
   input  logic                  req_tuser,  // [0] is_close
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [6:0] slot, [38:7] message_count, [39] zero
   output logic [STATUS_W-1:0]   rsp_tuser,  // [1:0] status
   input  logic                  csr_wr_en,
   input  logic [LIMIT_W-1:0]    csr_wr_data
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int LW = $clog2(TABLE_DEPTH + 1);
   localparam int CW = (LW > LIMIT_W) ? LW : LIMIT_W;
   localparam int PW = IW + SLOT_W;
   localparam logic [LW-1:0] DEPTH_L = LW'(TABLE_DEPTH);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SEARCH = 2'd1;
   localparam logic [1:0] S_UPDATE = 2'd2;
   localparam logic [1:0] S_SHIFT  = 2'd3;

   // Sequencer state
   logic [1:0]         state_ff, state_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [IW-1:0]      pos_ff, pos_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic               append_ff, append_in;
   logic               drop_ff, drop_in;
   logic [LW-1:0]      live_ff, live_in;
   logic [LIMIT_W-1:0] limit_ff;

   // Latched key of the item in flight
   logic [ADDR_W-1:0]  key_addr_ff;
   logic [PORT_W-1:0]  key_port_ff;
   logic               close_ff;

   // Table memory
   entry_type          mem [TABLE_DEPTH];
   entry_type          rd_data_ff;
   logic [IW-1:0]      rd_addr;
   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   entry_type          wr_data;

   logic               req_accept;
   logic               hit;
   logic               can_add;
   logic [COUNT_W-1:0] cnt_sat;
   logic [PW-1:0]      pos_wide;
   logic               rsp_ready;
   logic               rsp_load;
   result_type         res;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   assign hit = (rd_data_ff.addr == key_addr_ff) && (rd_data_ff.port == key_port_ff);

   // Room for a new key: below both the programmed limit and the depth
   assign can_add = (CW'(live_ff) < CW'(limit_ff)) && (live_ff < DEPTH_L);

   assign cnt_sat  = (cnt_ff == '1) ? cnt_ff : cnt_ff + 1'b1;
   assign pos_wide = PW'(pos_ff);

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      append_in = append_ff;
      drop_in   = drop_ff;
      live_in   = live_ff;
      rd_addr   = idx_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = '{addr: key_addr_ff, port: key_port_ff, count: cnt_sat};
      rsp_load  = 1'b0;
      res       = '{status: ST_DROPPED, slot: '0, count: '0};

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               idx_in    = '0;
               rd_addr   = '0;
               append_in = 1'b0;
               drop_in   = 1'b0;
               if (live_ff == '0) begin
                  // Empty table: straight to the miss decision
                  pos_in    = '0;
                  cnt_in    = '0;
                  append_in = can_add;
                  drop_in   = !can_add;
                  state_in  = S_UPDATE;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end

         S_SEARCH: begin
            // rd_data_ff holds the entry at idx_ff
            if (hit) begin
               pos_in   = idx_ff;
               cnt_in   = rd_data_ff.count;
               state_in = S_UPDATE;
            end else if (LW'(idx_ff) + 1'b1 == live_ff) begin
               pos_in    = live_ff[IW-1:0];
               cnt_in    = '0;
               append_in = can_add;
               drop_in   = !can_add;
               state_in  = S_UPDATE;
            end else begin
               idx_in  = idx_ff + 1'b1;
               rd_addr = idx_ff + 1'b1;
            end
         end

         S_UPDATE: begin
            if (rsp_ready) begin
               rsp_load = 1'b1;
               if (drop_ff) begin
                  state_in = S_IDLE;
               end else begin
                  res.status = close_ff ? ST_REMOVED : ST_COUNTED;
                  res.slot   = pos_wide[SLOT_W-1:0];
                  res.count  = cnt_sat;
                  if (!close_ff) begin
                     wr_en    = 1'b1;
                     state_in = S_IDLE;
                     if (append_ff) begin
                        live_in = live_ff + 1'b1;
                     end
                  end else if (append_ff) begin
                     // New key closed at once: nothing stays behind
                     state_in = S_IDLE;
                  end else if (LW'(pos_ff) + 1'b1 < live_ff) begin
                     idx_in   = pos_ff + 1'b1;
                     rd_addr  = pos_ff + 1'b1;
                     state_in = S_SHIFT;
                  end else begin
                     live_in  = live_ff - 1'b1;
                     state_in = S_IDLE;
                  end
               end
            end
         end

         S_SHIFT: begin
            // Move entry idx_ff down one slot, fetch the next one
            wr_en   = 1'b1;
            wr_addr = idx_ff - 1'b1;
            wr_data = rd_data_ff;
            if (LW'(idx_ff) + 1'b1 < live_ff) begin
               idx_in  = idx_ff + 1'b1;
               rd_addr = idx_ff + 1'b1;
            end else begin
               live_in  = live_ff - 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         live_ff   <= '0;
         limit_ff  <= LIMIT_RESET;
         append_ff <= 1'b0;
         drop_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         live_ff   <= live_in;
         append_ff <= append_in;
         drop_ff   <= drop_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      cnt_ff <= cnt_in;
      if (req_accept) begin
         key_addr_ff <= req_tdata[ADDR_W-1:0];
         key_port_ff <= req_tdata[ADDR_W+PORT_W-1:ADDR_W];
         close_ff    <= req_tuser;
      end
   end

   // Table memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   ftmc_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (rsp_load),
      .res        (res),
      .ready      (rsp_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Live count never exceeds the table
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= DEPTH_L)
      else $error("live count above table depth");

   // Live count moves by at most one per cycle
   a_live_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(live_ff) |->
         (live_ff == $past(live_ff) + 1'b1) || (live_ff + 1'b1 == $past(live_ff)))
      else $error("live count jumped");

   // Search only visits live entries
   a_search_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (LW'(idx_ff) < live_ff))
      else $error("search beyond live entries");

   // A dropped item reports slot and count zero
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_DROPPED) |-> (rsp_tdata == '0))
      else $error("dropped item carries data");

endmodule

/* sv/ftmc_rsp_reg.sv */
// Output register of the flow table message counter: holds one result item
// until the downstream side takes it. Depends on ftmc_pkg.
module ftmc_rsp_reg
   import ftmc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  result_type            res,
   output logic                  ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [6:0] slot, [38:7] message_count, [39] zero
   output logic [STATUS_W-1:0]   rsp_tuser   // [1:0] status
);

   logic       valid_ff, valid_in;
   result_type res_ff;

   assign ready = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, res_ff.count, res_ff.slot};
   assign rsp_tuser  = res_ff.status;

endmodule

/* tb/ftmc_flow_monitor.sv */
`timescale 1ns / 1ps
// Flow table monitor: watches the request, result and register ports of the
// flow table message counter, predicts each result and compares it.
// Depends on ftmc_pkg.
module ftmc_flow_monitor
   import ftmc_pkg::*;
#(
   parameter int TABLE_DEPTH = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic [STATUS_W-1:0]   rsp_tuser,
   input  logic                  csr_wr_en,
   input  logic [LIMIT_W-1:0]    csr_wr_data,
   output int                    results_owed,
   output int                    fail_count
);

   logic [ADDR_W-1:0]  flow_addr  [TABLE_DEPTH];
   logic [PORT_W-1:0]  flow_port  [TABLE_DEPTH];
   logic [COUNT_W-1:0] flow_count [TABLE_DEPTH];
   int                 live_flows;
   logic [LIMIT_W-1:0] flow_limit;
   result_type         pending_results [$];

   initial begin
      results_owed = 0;
      fail_count   = 0;
      live_flows   = 0;
      flow_limit   = LIMIT_RESET;
   end

   // Match the key, append it if there is room, bump the count, remove on close.
   function automatic result_type count_message(input logic [ADDR_W-1:0] addr,
                                                input logic [PORT_W-1:0] port,
                                                input logic              closing);
      result_type res;
      int         pos;
      int         cap;
      int         i;
      pos = -1;
      cap = (int'(flow_limit) < TABLE_DEPTH) ? int'(flow_limit) : TABLE_DEPTH;
      for (i = 0; i < live_flows; i++) begin
         if (pos < 0 && flow_addr[i] == addr && flow_port[i] == port) begin
            pos = i;
         end
      end
      if (pos < 0) begin
         if (live_flows >= cap) begin
            res.status = ST_DROPPED;
            res.slot   = '0;
            res.count  = '0;
            return res;
         end
         pos             = live_flows;
         flow_addr[pos]  = addr;
         flow_port[pos]  = port;
         flow_count[pos] = '0;
         live_flows++;
      end
      if (flow_count[pos] != '1) begin
         flow_count[pos] = flow_count[pos] + 1'b1;
      end
      res.status = closing ? ST_REMOVED : ST_COUNTED;
      res.slot   = SLOT_W'(pos);
      res.count  = flow_count[pos];
      if (closing) begin
         for (i = pos; i + 1 < live_flows; i++) begin
            flow_addr[i]  = flow_addr[i + 1];
            flow_port[i]  = flow_port[i + 1];
            flow_count[i] = flow_count[i + 1];
         end
         live_flows--;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         live_flows = 0;
         flow_limit = LIMIT_RESET;
         pending_results.delete();
      end else begin
         if (csr_wr_en) begin
            flow_limit = csr_wr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result: status %0d slot %0d message_count %0d",
                      rsp_tuser, rsp_tdata[SLOT_W-1:0], rsp_tdata[SLOT_W +: COUNT_W]);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[SLOT_W-1:0] !== want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot, rsp_tdata[SLOT_W-1:0]);
                  fail_count++;
               end
               if (rsp_tdata[SLOT_W +: COUNT_W] !== want.count) begin
                  $error("message_count: expected %0d, got %0d", want.count,
                         rsp_tdata[SLOT_W +: COUNT_W]);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            pending_results.push_back(count_message(req_tdata[ADDR_W-1:0],
                                                    req_tdata[ADDR_W +: PORT_W], req_tuser));
         end
      end
      results_owed <= pending_results.size();
   end

endmodule

/* tb/tb_flow_table_message_counter.sv */
`timescale 1ns / 1ps
// Testbench top for the flow table message counter: clock, reset, stimulus,
// flow control and verdict. Depends on ftmc_pkg, flow_table_message_counter and ftmc_flow_monitor.
module tb_flow_table_message_counter;
   import ftmc_pkg::*;

   localparam int TABLE_DEPTH = 128;
   localparam int KEY_POOL    = 160;
   localparam int PHASES      = 9;
   // Worst item: full search plus full shift-down, with margin.
   localparam int SETTLE      = 2 * TABLE_DEPTH + 8;
   localparam int LONG_HOLD   = 700;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;  // [31:0] source_address, [47:32] source_port
   logic                  req_tuser   = 1'b0;  // [0] is_close
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // [6:0] slot, [38:7] message_count, [39] zero
   logic [STATUS_W-1:0]   rsp_tuser;  // [1:0] status
   logic                  csr_wr_en   = 1'b0;
   logic [LIMIT_W-1:0]    csr_wr_data = '0;

   int results_owed;
   int fail_count;

   // Idle odds in percent; the receiver's is read by its own process.
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   logic long_hold_go  = 1'b0;

   // Key pool: neighbors share an address or a port so near-miss keys occur.
   logic [ADDR_W-1:0] pool_addr [KEY_POOL];
   logic [PORT_W-1:0] pool_port [KEY_POOL];

   // Per-phase register value, item count, keys in use, one close in N.
   int phase_limit [PHASES] = '{3, 1, 40, 255, 2, 128, 0, 200, 100};
   int phase_items [PHASES] = '{120, 80, 200, 330, 120, 200, 100, 150, 330};
   int phase_keys  [PHASES] = '{6, 3, 50, 150, 150, 140, 140, 20, 110};
   int phase_close [PHASES] = '{5, 3, 12, 60, 2, 40, 3, 8, 30};

   always #4 clock = ~clock;

   flow_table_message_counter #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   ftmc_flow_monitor #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_monitor (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .results_owed (results_owed),
      .fail_count   (fail_count)
   );

   // Result side: random back-pressure, plus one long hold-off counted here so
   // the block fills its output register and stalls its input.
   always @(posedge clock) begin
      int  hold_left;
      bit  hold_taken;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  = 0;
         hold_taken = 1'b0;
      end else if (long_hold_go && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Offer one item after a random gap; return at the edge that accepts it.
   // Valid stays high on return so back-to-back items follow without valid dropping.
   task automatic send_message(input logic [ADDR_W-1:0] addr,
                               input logic [PORT_W-1:0] port,
                               input logic              closing);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {port, addr};
      req_tuser  <= closing;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drop valid and hold until every predicted result has come back.
   task automatic wait_until_answered();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
   endtask

   // Write the limit only once the block is idle; a close may still be
   // shifting entries after its result went out, so let that finish first.
   task automatic set_entry_limit(input logic [LIMIT_W-1:0] value);
      wait_until_answered();
      repeat (SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin
            send_idle_pct  = 8;
            recv_idle_pct <= 78;
         end
         1: begin
            send_idle_pct  = 78;
            recv_idle_pct <= 8;
         end
         default: begin
            send_idle_pct  = 0;
            recv_idle_pct <= 0;
         end
      endcase
   endtask

   // Walk the pool in order so new flows keep arriving and the table fills,
   // revisit pool keys at random for hits, and mix in a few random keys as noise.
   task automatic run_phase(input int ph);
      int                cursor;
      int                idx;
      int                pick;
      logic [ADDR_W-1:0] addr;
      logic [PORT_W-1:0] port;
      logic              closing;
      cursor = 0;
      for (int n = 0; n < phase_items[ph]; n++) begin
         // In the last phase, pause the sender once mid-phase until everything is answered.
         if (ph == PHASES - 1 && n == phase_items[ph] / 2) begin
            wait_until_answered();
         end
         pick = $urandom_range(0, 15);
         if (pick == 0) begin
            addr = $urandom;
            port = PORT_W'($urandom);
         end else begin
            if (pick < 8) begin
               idx    = cursor;
               cursor = (cursor + 1) % phase_keys[ph];
            end else begin
               idx = $urandom_range(0, phase_keys[ph] - 1);
            end
            addr = pool_addr[idx];
            port = pool_port[idx];
         end
         closing = ($urandom_range(1, phase_close[ph]) == 1);
         send_message(addr, port, closing);
      end
   endtask

   initial begin
      for (int i = 0; i < KEY_POOL; i++) begin
         pool_addr[i] = (i % 4 == 1) ? pool_addr[i - 1] : $urandom;
         pool_port[i] = (i % 4 == 2) ? pool_port[i - 1] : PORT_W'($urandom);
      end
      set_idling(0);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, keys that differ in one part only,
      // close on an existing, a new and a middle entry, at the reset limit.
      send_message(32'h0000_0000, 16'h0000, 1'b0);
      send_message(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
      send_message(32'h0000_0000, 16'h0000, 1'b0);
      send_message(32'h0000_0000, 16'hFFFF, 1'b0);
      send_message(32'hFFFF_FFFF, 16'h0000, 1'b0);
      send_message(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
      send_message(32'h0000_0000, 16'hFFFF, 1'b0);
      send_message(32'hA5A5_5A5A, 16'h1234, 1'b1);
      send_message(32'h0000_0000, 16'h0000, 1'b1);

      // Limit of zero: new keys drop, a close on an unknown key drops,
      // and the limit below the live count still lets old flows count.
      set_entry_limit(8'd0);
      send_message(32'hC0A8_0001, 16'h0050, 1'b0);
      send_message(32'h0000_0000, 16'hFFFF, 1'b0);
      send_message(32'h0000_0001, 16'h0001, 1'b1);

      // Limit equal to the live count: full until a close makes room.
      set_entry_limit(8'd2);
      send_message(32'h0000_0002, 16'h0002, 1'b0);
      send_message(32'hFFFF_FFFF, 16'h0000, 1'b1);
      send_message(32'h0000_0002, 16'h0002, 1'b0);
      send_message(32'h0000_0003, 16'h0003, 1'b0);

      // Random phases: the table carries over, so some phases start above
      // their limit and drain through closes.
      for (int ph = 0; ph < PHASES; ph++) begin
         set_entry_limit(phase_limit[ph][LIMIT_W-1:0]);
         set_idling(ph / 3);
         if (ph == 6) begin
            long_hold_go <= 1'b1;
         end
         run_phase(ph);
      end

      wait_until_answered();
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Bound the run well past the slowest legal completion.
   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
